@@ rtl/core/u8sf_pkg.sv @@
// ----------------------------------------------------------------------------
// u8sf_pkg
// Shared types and constants for the UTF-8 structure filter.
// ----------------------------------------------------------------------------
package u8sf_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned GroupMax  = 4;
  localparam int unsigned IdxW      = $clog2(GroupMax);
  localparam int unsigned QDepth    = 8;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam logic [7:0] AsciiMax   = 8'h7F;
  localparam logic [7:0] Mask2      = 8'hE0;
  localparam logic [7:0] Lead2      = 8'hC0;
  localparam logic [7:0] Mask3      = 8'hF0;
  localparam logic [7:0] Lead3      = 8'hE0;
  localparam logic [7:0] Mask4      = 8'hF8;
  localparam logic [7:0] Lead4      = 8'hF0;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContCode   = 8'h80;

  localparam logic [2:0] LenNone    = 3'd0;
  localparam logic [2:0] LenTwo     = 3'd2;
  localparam logic [2:0] LenThree   = 3'd3;
  localparam logic [2:0] LenFour    = 3'd4;

  // one request from the front: a group of result bytes for one input byte
  typedef struct packed {
    logic [GroupMax-1:0][ByteW-1:0] data;
    logic [IdxW-1:0]                last_idx;
    logic                           has_byte;
    logic                           eob;
  } cmd_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = LenNone;
    if ((b & Mask2) == Lead2) len = LenTwo;
    else if ((b & Mask3) == Lead3) len = LenThree;
    else if ((b & Mask4) == Lead4) len = LenFour;
    return len;
  endfunction

endpackage

@@ rtl/core/utf8_structure_filter_top.sv @@
// ----------------------------------------------------------------------------
// utf8_structure_filter_top
// UTF-8 structure filter: passes ASCII and complete multi-byte sequences.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while the queue is not full and one
// result per cycle while m_tready is high; a completed sequence releases up
// to four results, buffered in an eight-entry queue.
// Reset: synchronous; clears held count, sequence length, queue and output
// valid. Held sequence bytes are not cleared.
// ----------------------------------------------------------------------------
module utf8_structure_filter_top
  import u8sf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [0] has_byte, [1] run_last
);

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  u8sf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_eob   (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  u8sf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .empty    (q_empty),
    .pop      (pop),
    .head     (head)
  );

  u8sf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

@@ rtl/core/u8sf_front.sv @@
// ----------------------------------------------------------------------------
// u8sf_front
// Accepts raw bytes, tracks the held sequence and issues result groups.
// ----------------------------------------------------------------------------
module u8sf_front
  import u8sf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_byte,
  input  logic             in_eob,
  input  logic             q_full,
  output logic             push,
  output cmd_t             cmd
);

  logic [2:0][ByteW-1:0] pend;
  logic [2:0][ByteW-1:0] pend_next;
  logic [1:0]            pend_cnt;
  logic [1:0]            pend_cnt_next;
  logic [2:0]            seq_len;
  logic [2:0]            seq_len_next;
  logic                  take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    logic       handled;
    logic       emit;
    logic [2:0] len;
    pend_next     = pend;
    pend_cnt_next = pend_cnt;
    seq_len_next  = seq_len;
    handled       = 1'b0;
    emit          = 1'b0;
    len           = lead_length(in_byte);
    cmd.data      = '0;
    cmd.last_idx  = '0;
    cmd.has_byte  = 1'b0;
    cmd.eob       = in_eob;

    if (seq_len != LenNone) begin
      if ((in_byte & ContMask) == ContCode) begin
        handled = 1'b1;
        if (({1'b0, pend_cnt} + 3'd1) >= seq_len) begin
          emit         = 1'b1;
          cmd.last_idx = pend_cnt;
          for (int i = 0; i < 3; i++) begin
            cmd.data[i] = (IdxW'(i) < pend_cnt) ? pend[i] : in_byte;
          end
          cmd.data[GroupMax-1] = in_byte;
          pend_cnt_next = '0;
          seq_len_next  = LenNone;
        end else if (pend_cnt < 2'd3) begin
          pend_next[pend_cnt] = in_byte;
          pend_cnt_next       = pend_cnt + 2'd1;
        end else begin
          pend_cnt_next = '0;
          seq_len_next  = LenNone;
        end
      end else begin
        pend_cnt_next = '0;
        seq_len_next  = LenNone;
      end
    end

    if (!handled) begin
      if (in_byte <= AsciiMax) begin
        emit         = 1'b1;
        cmd.data[0]  = in_byte;
        cmd.last_idx = '0;
      end else if (len != LenNone) begin
        pend_next[0]  = in_byte;
        pend_cnt_next = 2'd1;
        seq_len_next  = len;
      end
    end

    if (in_eob) begin
      pend_cnt_next = '0;
      seq_len_next  = LenNone;
    end

    cmd.has_byte = emit;
    push         = take && (emit || in_eob);
  end

  always_ff @(posedge clk) begin
    if (take) pend <= pend_next;
    if (rst) begin
      pend_cnt <= '0;
      seq_len  <= LenNone;
    end else if (take) begin
      pend_cnt <= pend_cnt_next;
      seq_len  <= seq_len_next;
    end
  end

endmodule

@@ rtl/core/u8sf_queue.sv @@
// ----------------------------------------------------------------------------
// u8sf_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module u8sf_queue
  import u8sf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic empty,
  input  logic pop,
  output cmd_t head
);

  cmd_t             slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full  = (count == QCntW'(QDepth));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPtrW'(1);
      if (pop) rd_ptr <= rd_ptr + QPtrW'(1);
      if (push && !pop) count <= count + QCntW'(1);
      else if (pop && !push) count <= count - QCntW'(1);
    end
  end

endmodule

@@ rtl/core/u8sf_back.sv @@
// ----------------------------------------------------------------------------
// u8sf_back
// Walks queued groups into the output register, one result per free cycle.
// ----------------------------------------------------------------------------
module u8sf_back
  import u8sf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  output logic [1:0]  m_tuser
);

  logic [IdxW-1:0] idx;
  logic            load;
  logic            last;

  assign load = !q_empty && (!m_tvalid || m_tready);
  assign last = (idx == head.last_idx);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata    <= head.has_byte ? head.data[idx] : '0;
      m_tlast    <= last && head.eob;
      m_tuser[0] <= head.has_byte;
      m_tuser[1] <= last;
    end
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (load) idx <= last ? '0 : idx + IdxW'(1);
    end
  end

endmodule

@@ tb/sv/utf8_structure_filter_top_tb.sv @@
// ----------------------------------------------------------------------------
// utf8_structure_filter_top_tb
// Drives byte buffers into the UTF-8 structure filter and checks every output
// request against an in-bench model of the filter: ASCII pass-through, whole
// multi-byte sequences, dropped stray and invalid bytes, broken sequences and
// end-of-buffer flushes. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf8_structure_filter_top_tb
  import u8sf_pkg::*;
();

  typedef struct {
    logic [7:0] data;
    logic       eob;
  } byte_req_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       buffer_done;
    logic       run_last;
  } filter_result_t;

  class filter_scoreboard;
    filter_result_t awaited[$];
    logic [7:0]     held[3];
    int unsigned    held_cnt;
    logic [2:0]     seq_len;
    int unsigned    fail_count;
    int unsigned    n_requests;
    int unsigned    n_buffers;
    int unsigned    n_results;
    int unsigned    n_sequences;

    function new();
      held_cnt    = 0;
      seq_len     = LenNone;
      fail_count  = 0;
      n_requests  = 0;
      n_buffers   = 0;
      n_results   = 0;
      n_sequences = 0;
    endfunction

    function logic [2:0] seq_length_of(logic [7:0] b);
      if ((b & Mask2) == Lead2) return LenTwo;
      if ((b & Mask3) == Lead3) return LenThree;
      if ((b & Mask4) == Lead4) return LenFour;
      return LenNone;
    endfunction

    function void drop_held();
      held_cnt = 0;
      seq_len  = LenNone;
    endfunction

    function void note_request(logic [7:0] b, logic eob);
      logic [7:0]     emit[$];
      logic [2:0]     len;
      bit             taken;
      filter_result_t r;
      taken = 0;
      n_requests++;
      if (eob) n_buffers++;
      if (seq_len != LenNone) begin
        if ((b & ContMask) == ContCode) begin
          taken = 1;
          if (held_cnt + 1 >= seq_len) begin
            for (int i = 0; i < held_cnt && i < 3; i++) emit = {emit, held[i]};
            emit = {emit, b};
            n_sequences++;
            drop_held();
          end else if (held_cnt < 3) begin
            held[held_cnt] = b;
            held_cnt++;
          end else begin
            drop_held();
          end
        end else begin
          drop_held();
        end
      end
      if (!taken) begin
        if (b <= AsciiMax) begin
          emit = {emit, b};
        end else begin
          len = seq_length_of(b);
          if (len != LenNone) begin
            held[0]  = b;
            held_cnt = 1;
            seq_len  = len;
          end
        end
      end
      if (eob) drop_held();
      foreach (emit[k]) begin
        r.out_byte    = emit[k];
        r.has_byte    = 1'b1;
        r.run_last    = (k == emit.size() - 1);
        r.buffer_done = r.run_last && eob;
        awaited = {awaited, r};
      end
      if (emit.size() == 0 && eob) begin
        r.out_byte    = 8'h00;
        r.has_byte    = 1'b0;
        r.buffer_done = 1'b1;
        r.run_last    = 1'b1;
        awaited = {awaited, r};
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
    endtask

    task check_result(logic [7:0] data, logic tlast, logic [1:0] tuser);
      filter_result_t e;
      n_results++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result byte %02h", data));
        return;
      end
      e = awaited.pop_front();
      if (tuser[0] !== e.has_byte)
        report($sformatf("has_byte %b, want %b", tuser[0], e.has_byte));
      if (data !== e.out_byte)
        report($sformatf("out_byte %02h, want %02h", data, e.out_byte));
      if (tlast !== e.buffer_done)
        report($sformatf("buffer_done %b, want %b", tlast, e.buffer_done));
      if (tuser[1] !== e.run_last)
        report($sformatf("run_last %b, want %b", tuser[1], e.run_last));
    endtask
  endclass

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;
  logic       calm     = 1'b0;

  filter_scoreboard sb = new();
  byte_req_t        stim_q[$];

  utf8_structure_filter_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("simulation failed");
    $finish;
  end

  function automatic void push_req(logic [7:0] b, logic eob);
    byte_req_t q;
    q.data = b;
    q.eob  = eob;
    stim_q = {stim_q, q};
  endfunction

  function automatic logic [7:0] rand_cont();
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic logic [7:0] rand_lead(int unsigned len);
    case (len)
      2: return {3'b110, 5'($urandom)};
      3: return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  function automatic logic rand_eob();
    return $urandom_range(99) < 8;
  endfunction

  function automatic void build_directed();
    push_req(8'h00, 0); push_req(8'h7F, 0);
    push_req(8'h80, 0); push_req(8'hF8, 0); push_req(8'hFF, 0);
    push_req(8'hC2, 0); push_req(8'hA9, 0);
    push_req(8'hE2, 0); push_req(8'h82, 0); push_req(8'hAC, 0);
    push_req(8'hF0, 0); push_req(8'h9F, 0); push_req(8'h98, 0); push_req(8'h80, 0);
    push_req(8'hE2, 0); push_req(8'h41, 0);
    push_req(8'hE2, 0); push_req(8'hC3, 0); push_req(8'hA9, 0);
    push_req(8'h55, 1);
    push_req(8'hC3, 1);
    push_req(8'hF4, 0); push_req(8'h8F, 0); push_req(8'hBF, 0); push_req(8'hBF, 1);
  endfunction

  function automatic void build_random(int unsigned target);
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    while (stim_q.size() < target) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        push_req(8'($urandom_range(8'h7F)), rand_eob());
      end else if (kind < 75) begin
        len = $urandom_range(4, 2);
        push_req(rand_lead(len), rand_eob());
        for (int i = 1; i < len; i++) push_req(rand_cont(), rand_eob());
      end else if (kind < 90) begin
        push_req(8'($urandom_range(255)), rand_eob());
      end else begin
        len = $urandom_range(4, 2);
        cut = $urandom_range(len - 2);
        push_req(rand_lead(len), rand_eob());
        for (int i = 0; i < cut; i++) push_req(rand_cont(), rand_eob());
      end
    end
  endfunction

  task automatic send_byte(byte_req_t q);
    while (!calm && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= q.data;
    s_tlast  <= q.eob;
    do @(posedge clk); while (!s_tready);
    sb.note_request(q.data, q.eob);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
      m_tready <= calm || ($urandom_range(99) >= 9);
    end
  end

  initial begin
    int unsigned n_directed;
    build_directed();
    n_directed = stim_q.size();
    build_random(260);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (stim_q[i]) begin
      calm <= (i >= 120 && i < 200);
      send_byte(stim_q[i]);
    end
    s_tvalid <= 1'b0;
    calm     <= 1'b0;
    for (int n = 0; n < 5000 && sb.awaited.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
    $display("sent %0d bytes in %0d buffers (%0d directed), checked %0d results",
             sb.n_requests, sb.n_buffers, n_directed, sb.n_results);
    $display("whole multi-byte sequences passed: %0d, mismatches: %0d",
             sb.n_sequences, sb.fail_count);
    if (sb.fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
